// ===== design/nhc_pkg.sv =====
package nhc_pkg;

    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_MEASURE  = 2'd1;
    localparam logic [1:0] KIND_COLORIZE = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    localparam int COUNT_W = 32;
    localparam int LEVEL_W = 10;
    localparam int MANT_W  = 32;
    localparam int NUM_W   = 42;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [LEVEL_W-1:0] level;
    } pixel_t;

    function automatic pixel_t color_map(input logic [LEVEL_W-1:0] lv);
        pixel_t p;
        p.level = lv;
        if (lv == '0)
        begin
            p.red = 8'd255; p.green = 8'd255; p.blue = 8'd255;
        end
        else
        begin
            unique case (lv[9:8])
                2'd0:
                begin
                    p.red = 8'd0; p.green = lv[7:0]; p.blue = 8'd255;
                end
                2'd1:
                begin
                    p.red = 8'd0; p.green = 8'd255; p.blue = ~lv[7:0];
                end
                2'd2:
                begin
                    p.red = lv[7:0]; p.green = 8'd255; p.blue = 8'd0;
                end
                default:
                begin
                    p.red = 8'd255; p.green = ~lv[7:0]; p.blue = 8'd0;
                end
            endcase
        end
        return p;
    endfunction

endpackage

// ===== design/nhc_log2.sv =====
module nhc_log2 #(
    parameter int FRAC_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nhc_pkg::COUNT_W-1:0]  x,
    output logic                         done,
    output logic [FRAC_BITS+4:0]         result
);

    localparam int RES_W = FRAC_BITS + 5;
    localparam int CNT_W = $clog2(FRAC_BITS + 33);

    logic                            busy_reg, busy_next;
    logic                            norm_reg, norm_next;
    logic                            done_reg, done_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [nhc_pkg::COUNT_W-1:0]     m_reg, m_next;
    logic [4:0]                      e_reg, e_next;
    logic [RES_W-1:0]                res_reg, res_next;
    logic [2*nhc_pkg::COUNT_W-1:0]   sq;

    // m holds mantissa with 31 fraction bits; one squaring per step
    assign sq = 64'(m_reg) * 64'(m_reg);

    always_comb
    begin
        busy_next = busy_reg;
        norm_next = norm_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        e_next    = e_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            norm_next = 1'b1;
            m_next    = x;
            e_next    = 5'd31;
            cnt_next  = '0;
        end
        else if (busy_reg && norm_reg)
        begin
            priority if (m_reg == '0)
            begin
                busy_next = 1'b0;
                res_next  = '0;
                done_next = 1'b1;
            end
            else if (m_reg[31])
            begin
                norm_next = 1'b0;
                res_next  = RES_W'(e_reg);
            end
            else
            begin
                m_next = {m_reg[30:0], 1'b0};
                e_next = e_reg - 5'd1;
            end
        end
        else if (busy_reg)
        begin
            res_next = {res_reg[RES_W-2:0], sq[63]};
            m_next   = sq[63] ? sq[63:32] : sq[62:31];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            norm_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            norm_reg <= norm_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        e_reg   <= e_next;
        res_reg <= res_next;
    end

endmodule

// ===== design/nhc_divider.sv =====
module nhc_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [nhc_pkg::MANT_W-1:0]         num,
    input  logic [nhc_pkg::MANT_W-1:0]         den,
    output logic                               done,
    output logic [nhc_pkg::LEVEL_W-1:0]        level
);

    localparam int W = nhc_pkg::NUM_W;
    localparam int CNT_W = $clog2(W + 1);

    logic                      busy_reg, busy_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [W-1:0]              n_reg, n_next;
    logic [nhc_pkg::MANT_W-1:0] rem_reg, rem_next;
    logic [W-1:0]              q_reg, q_next;
    logic [nhc_pkg::MANT_W-1:0] d_reg, d_next;
    logic                      zero_reg, zero_next;
    logic [nhc_pkg::MANT_W:0]  trial;
    logic [nhc_pkg::MANT_W+1:0] diff;

    // restoring division of num*1023 by den, one quotient bit per cycle
    assign trial = {rem_reg, n_reg[W-1]};
    assign diff  = {1'b0, trial} - {2'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        zero_next = zero_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = ({10'd0, num} << 10) - {10'd0, num};
            rem_next  = '0;
            q_next    = '0;
            d_next    = den;
            zero_next = (num == '0) || (den == '0);
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (!diff[nhc_pkg::MANT_W+1])
            begin
                rem_next = diff[nhc_pkg::MANT_W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[nhc_pkg::MANT_W-1:0];
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (zero_reg)
            level = '0;
        else if (q_reg > W'(nhc_pkg::LEVEL_MAX))
            level = nhc_pkg::LEVEL_MAX;
        else if (q_reg == '0)
            level = 10'd1;
        else
            level = q_reg[nhc_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        zero_reg <= zero_next;
    end

endmodule

// ===== design/normalized_heatmap_colorizer_unit.sv =====
// In linear mode a colorize goes straight to a 42-step restoring divider; in log mode
// it first takes log2 of the count and then of the maximum (bit-serial normalise,
// squaring log2) and then divides. Clear, measure and unused kinds produce no result.
// No new input is taken until a colorize result is loaded; a waiting result holds the
// next colorize in its wait state, and all input stalls meanwhile.
// Reset (rst_n, asynchronous): maximum and log_scale cleared.
module normalized_heatmap_colorizer_unit #(
    parameter int LOG_FRACTION_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // hit_count[31:0]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // red, green, blue, level[9:0], zero pad
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int LOG_W = LOG_FRACTION_BITS + 5;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOGX = 3'd1;
    localparam logic [2:0] ST_LOGM = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [31:0]                   max_reg, max_next;
    logic                          log_scale_reg;
    logic [31:0]                   count_reg, count_next;
    logic [LOG_W-1:0]              logx_reg, logx_next;
    logic                          out_valid_reg, out_valid_next;
    nhc_pkg::pixel_t               pix_reg, pix_next;

    logic                          acc;
    logic                          log_start, log_done;
    logic [31:0]                   log_in;
    logic [LOG_W-1:0]              log_res;
    logic                          div_start, div_done;
    logic [31:0]                   div_num, div_den;
    logic [nhc_pkg::LEVEL_W-1:0]   div_level;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    nhc_log2 #(.FRAC_BITS(LOG_FRACTION_BITS)) u_log (
        .clk(clk), .rst_n(rst_n), .start(log_start), .x(log_in),
        .done(log_done), .result(log_res)
    );

    nhc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .level(div_level)
    );

    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        count_next     = count_reg;
        logx_next      = logx_reg;
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        log_start      = 1'b0;
        log_in         = count_reg;
        div_start      = 1'b0;
        div_num        = count_reg;
        div_den        = max_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    count_next = s_axis_tdata[31:0];
                    priority if (s_axis_tuser == nhc_pkg::KIND_CLEAR)
                        max_next = '0;
                    else if (s_axis_tuser == nhc_pkg::KIND_MEASURE)
                    begin
                        if (s_axis_tdata[31:0] > max_reg)
                            max_next = s_axis_tdata[31:0];
                    end
                    else if (s_axis_tuser == nhc_pkg::KIND_COLORIZE && max_reg != '0)
                    begin
                        if (log_scale_reg)
                        begin
                            log_start  = 1'b1;
                            log_in     = s_axis_tdata[31:0];
                            state_next = ST_LOGX;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_num    = s_axis_tdata[31:0];
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_LOGX:
            begin
                if (log_done)
                begin
                    logx_next  = log_res;
                    state_next = ST_LOGM;
                    log_start  = 1'b1;
                    log_in     = max_reg;
                end
            end
            ST_LOGM:
            begin
                if (log_done)
                begin
                    div_start  = 1'b1;
                    div_num    = 32'(logx_reg);
                    div_den    = 32'(log_res);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    pix_next       = nhc_pkg::color_map(div_level);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, pix_reg.level, pix_reg.blue, pix_reg.green, pix_reg.red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            log_scale_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                log_scale_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        logx_reg  <= logx_next;
        pix_reg   <= pix_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("input taken while busy");

    a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WAIT)
        else $error("result without division");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(pix_reg))
        else $error("result dropped");

endmodule

// ===== tb/sv/nhc_scoreboard.sv =====
module nhc_scoreboard #(
    parameter int LOG_FRACTION_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // hit_count[31:0]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // red, green, blue, level[9:0], zero pad
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output int          fail_count,
    output int          pending
);

    logic [nhc_pkg::COUNT_W-1:0] peak_count;
    logic                        log_mode;
    nhc_pkg::pixel_t             expected_pixels[$];

    function automatic logic [63:0] log2_q(input logic [31:0] x);
        int          top;
        logic [63:0] mant;
        logic [63:0] sq;
        logic [63:0] acc;
        if (x == '0)
            return '0;
        top = 0;
        for (int i = 0; i < 32; i++)
            if (x[i])
                top = i;
        mant = 64'(x) << (31 - top);
        acc = 64'(top);
        for (int i = 0; i < LOG_FRACTION_BITS; i++)
        begin
            sq = mant * mant;
            acc = acc << 1;
            if (sq[63])
            begin
                acc[0] = 1'b1;
                mant = sq >> 32;
            end
            else
                mant = sq >> 31;
        end
        return acc;
    endfunction

    function automatic logic [nhc_pkg::LEVEL_W-1:0] scale_to_level(input logic [63:0] num,
                                                                   input logic [63:0] den);
        logic [63:0] q;
        if (num == '0 || den == '0)
            return '0;
        q = (num * 64'd1023) / den;
        if (q > 64'd1023)
            q = 64'd1023;
        if (q == '0)
            q = 64'd1;
        return q[nhc_pkg::LEVEL_W-1:0];
    endfunction

    function automatic nhc_pkg::pixel_t colour_for_level(input logic [nhc_pkg::LEVEL_W-1:0] lv);
        nhc_pkg::pixel_t p;
        int              v;
        v = int'(lv);
        p.level = lv;
        if (v == 0)
        begin
            p.red = 8'd255; p.green = 8'd255; p.blue = 8'd255;
        end
        else if (v < 256)
        begin
            p.red = 8'd0; p.green = 8'(v); p.blue = 8'd255;
        end
        else if (v < 512)
        begin
            p.red = 8'd0; p.green = 8'd255; p.blue = 8'(511 - v);
        end
        else if (v < 768)
        begin
            p.red = 8'(v - 512); p.green = 8'd255; p.blue = 8'd0;
        end
        else
        begin
            p.red = 8'd255; p.green = 8'(1023 - v); p.blue = 8'd0;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nhc_pkg::pixel_t             want;
        nhc_pkg::pixel_t             got;
        logic [nhc_pkg::LEVEL_W-1:0] lv;
        logic [31:0]                 cnt;
        if (!rst_n)
        begin
            peak_count <= '0;
            log_mode <= 1'b0;
            fail_count <= 0;
            pending <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red = m_axis_tdata[7:0];
                got.green = m_axis_tdata[15:8];
                got.blue = m_axis_tdata[23:16];
                got.level = m_axis_tdata[33:24];
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result rgb=%0d,%0d,%0d level=%0d", $time,
                             got.red, got.green, got.blue, got.level);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected rgb=%0d,%0d,%0d level=%0d, %s",
                                 $time, want.red, want.green, want.blue, want.level,
                                 $sformatf("actual rgb=%0d,%0d,%0d level=%0d",
                                           got.red, got.green, got.blue, got.level));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cnt = s_axis_tdata[31:0];
                case (s_axis_tuser)
                    nhc_pkg::KIND_CLEAR:
                        peak_count <= '0;
                    nhc_pkg::KIND_MEASURE:
                        if (cnt > peak_count)
                            peak_count <= cnt;
                    nhc_pkg::KIND_COLORIZE:
                        if (peak_count != '0)
                        begin
                            if (log_mode)
                                lv = scale_to_level(log2_q(cnt), log2_q(peak_count));
                            else
                                lv = scale_to_level(64'(cnt), 64'(peak_count));
                            expected_pixels.push_back(colour_for_level(lv));
                        end
                    default:
                        ;
                endcase
            end
            if (cfg_we)
                log_mode <= cfg_wdata;
            pending <= expected_pixels.size();
        end
    end

endmodule

// ===== tb/sv/tb_normalized_heatmap_colorizer_unit.sv =====
module tb_normalized_heatmap_colorizer_unit;

    localparam int SETTLE_CYCLES = 150;
    localparam int IDLE_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_wdata;
    int          fail_count;
    int          pending;
    logic        hold_off;
    int          idle_cycles;

    normalized_heatmap_colorizer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    nhc_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 2000);
            2: return 32'd1 << $urandom_range(0, 31);
            3: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [31:0] cnt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= cnt;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 4))
                    @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int nmeas;
        int ncol;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = nhc_pkg::KIND_CLEAR;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        hold_off = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd5);
        send_item(nhc_pkg::KIND_MEASURE, 32'hFFFF_FFFF);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd0);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd1);
        send_item(nhc_pkg::KIND_COLORIZE, 32'hFFFF_FFFF);
        send_item(nhc_pkg::KIND_COLORIZE, 32'h7FFF_FFFF);
        send_item(nhc_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
        send_item(nhc_pkg::KIND_MEASURE, 32'd1000);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd2000);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd999);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd300);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd600);
        send_item(nhc_pkg::KIND_UNUSED, 32'd500);
        send_item(nhc_pkg::KIND_CLEAR, 32'd0);
        send_item(nhc_pkg::KIND_MEASURE, 32'd1);
        write_mode(1'b1);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd1);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd7);
        send_item(nhc_pkg::KIND_MEASURE, 32'hFFFF_FFFF);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd0);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd1);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd2);
        send_item(nhc_pkg::KIND_COLORIZE, 32'hFFFF_FFFF);
        send_item(nhc_pkg::KIND_COLORIZE, 32'd65536);

        hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(nhc_pkg::KIND_COLORIZE, $urandom());

        sent = 0;
        while (sent < 800)
        begin
            if ($urandom_range(0, 4) == 0)
                write_mode($urandom_range(0, 1));
            send_item(nhc_pkg::KIND_CLEAR, $urandom());
            nmeas = $urandom_range(0, 6);
            ncol = $urandom_range(1, 12);
            for (int i = 0; i < nmeas; i++)
                send_item(nhc_pkg::KIND_MEASURE, pick_count());
            for (int i = 0; i < ncol; i++)
            begin
                case ($urandom_range(0, 15))
                    0: send_item(nhc_pkg::KIND_UNUSED, $urandom());
                    1: send_item(nhc_pkg::KIND_MEASURE, pick_count());
                    default: send_item(nhc_pkg::KIND_COLORIZE, pick_count());
                endcase
            end
            sent += 1 + nmeas + ncol;
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/nhc_pkg.sv
design/nhc_log2.sv
design/nhc_divider.sv
design/normalized_heatmap_colorizer_unit.sv
tb/sv/nhc_scoreboard.sv
tb/sv/tb_normalized_heatmap_colorizer_unit.sv
